FILE: rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL.
// All checks run on clk and are off while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property check on the block clock.
`define ASSERT_CLK(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("assertion failed");

// Condition that must never be seen on the block clock.
`define ASSERT_NEVER(label, cond) \
	`ASSERT_CLK(label, !(cond))

`endif

FILE: rtl/core/lksm_pkg.sv
package lksm_pkg;

	// Sizing
	localparam int MAX_SEQUENCES = 32;
	localparam int MAX_KEYS      = 8;
	localparam int POS_W         = 8;
	localparam int SEQ_W         = $clog2(MAX_SEQUENCES);
	localparam int KEY_IDX_W     = $clog2(MAX_KEYS);
	localparam int KEY_CNT_W     = $clog2(MAX_KEYS + 1);
	localparam int TBL_AW        = SEQ_W + KEY_IDX_W;

	// Item field widths
	localparam int CMD_W  = 3;
	localparam int SIDX_W = 5;
	localparam int KIDX_W = 3;
	localparam int SLEN_W = 4;
	localparam int ACT_W  = 2;

	// Configuration port
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 16;
	localparam int NUM_SEQ_W   = 6;
	localparam int TIMEOUT_W   = 16;
	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = TIMEOUT_W'(500);

	localparam logic [CFG_IDX_W-1:0] REG_NUM_SEQUENCES = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS = 1'b1;

	typedef enum logic [CMD_W-1:0] {
		CMD_LOAD     = 3'd0,
		CMD_ACTIVATE = 3'd1,
		CMD_PRESS    = 3'd2,
		CMD_RELEASE  = 3'd3,
		CMD_TICK     = 3'd4
	} cmd_t;

	typedef enum logic [ACT_W-1:0] {
		ACT_NONE    = 2'd0,
		ACT_PRESS   = 2'd1,
		ACT_RELEASE = 2'd2,
		ACT_TAP     = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_WALK,
		ST_DRAIN,
		ST_RESOLVE,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic             consumed;
		action_t          action;
		logic [SEQ_W-1:0] seq;
		logic             refused;
	} result_t;

	typedef struct packed {
		logic push;
		logic remove;
		logic clear;
	} held_op_t;

	typedef struct packed {
		logic [MAX_SEQUENCES-1:0] keep;
		logic                     complete;
		logic                     longer;
		logic [SEQ_W-1:0]         done;
	} walk_res_t;

endpackage

FILE: rtl/core/lksm_table_ram.sv
module lksm_table_ram #(
	parameter int AW = 8,
	parameter int DW = 8
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/core/lksm_held.sv
module lksm_held import lksm_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  held_op_t             op,
	input  logic [POS_W-1:0]     pos,
	output logic                 hit,
	output logic [KEY_CNT_W-1:0] count
);

	logic [POS_W-1:0]     held_q [MAX_KEYS];
	logic [KEY_CNT_W-1:0] count_q;
	logic [MAX_KEYS-1:0]  match;
	logic [KEY_IDX_W-1:0] first;
	logic                 room;

	assign room  = count_q < KEY_CNT_W'(MAX_KEYS);
	assign count = count_q;

	// compare every live entry, lowest match wins
	always_comb begin
		first = '0;
		for (int i = 0; i < MAX_KEYS; i++) begin
			match[i] = (KEY_CNT_W'(i) < count_q) && (held_q[i] == pos);
		end
		for (int i = MAX_KEYS - 1; i >= 0; i--) begin
			if (match[i]) begin
				first = KEY_IDX_W'(i);
			end
		end
		hit = |match;
	end

	// fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (op.clear) begin
			count_q <= '0;
		end else if (op.push && room) begin
			count_q <= count_q + KEY_CNT_W'(1);
		end else if (op.remove && hit) begin
			count_q <= count_q - KEY_CNT_W'(1);
		end
	end

	// append at the tail, or close the gap left by a removed key
	always_ff @(posedge clk) begin
		if (op.push && room) begin
			held_q[count_q[KEY_IDX_W-1:0]] <= pos;
		end else if (op.remove && hit) begin
			for (int j = 0; j < MAX_KEYS - 1; j++) begin
				if (KEY_IDX_W'(j) >= first) begin
					held_q[j] <= held_q[j+1];
				end
			end
		end
	end

endmodule

FILE: rtl/core/lksm_walk.sv
module lksm_walk import lksm_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 clr,
	input  logic                 step,
	input  logic [SEQ_W-1:0]     idx,
	input  logic                 cand,
	input  logic [KEY_CNT_W-1:0] len,
	input  logic [KEY_CNT_W-1:0] count,
	input  logic [POS_W-1:0]     pos,
	input  logic [POS_W-1:0]     rd_data,
	output walk_res_t            res
);

	walk_res_t res_q;
	logic      hit;
	logic      ends;

	// one sequence per cycle: still a candidate, slot inside length, key equal
	assign hit  = step && cand && (count < len) && (rd_data == pos);
	assign ends = len == (count + KEY_CNT_W'(1));
	assign res  = res_q;

	// narrowed set and ending sequences seen so far
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q <= '0;
		end else if (clr) begin
			res_q <= '0;
		end else if (hit) begin
			res_q.keep[idx] <= 1'b1;
			if (ends) begin
				res_q.complete <= 1'b1;
				res_q.done     <= idx;
			end else begin
				res_q.longer <= 1'b1;
			end
		end
	end

endmodule

FILE: rtl/core/leader_key_sequence_matcher.sv
// Channel  Direction  Handshake                 Payload
// in       input      in_valid / in_ready       cmd, seq_index, key_index, seq_length, position
// out      output     out_valid / out_ready     consumed, action, action_seq, refused
// cfg      input      cfg_we                    cfg_index, cfg_data
//
// Every item gives one result. Load, activate, release, tick: idle, decode, finish.
// A press while matching walks all MAX_SEQUENCES table entries through the single
// table read port, one per cycle, then drains the read stage and resolves.
// A press past MAX_KEYS skips the walk and goes from decode straight to resolve.
// Reset clears all control state and the length table; no clearing pass.
// in_ready is high only in idle; a result waiting at the output lets the next
// item in, and only a second finished result waits for out_ready.
module leader_key_sequence_matcher import lksm_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [CMD_W-1:0]      cmd,
	input  logic [SIDX_W-1:0]     seq_index,
	input  logic [KIDX_W-1:0]     key_index,
	input  logic [SLEN_W-1:0]     seq_length,
	input  logic [POS_W-1:0]      position,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  consumed,
	output logic [ACT_W-1:0]      action,
	output logic [SEQ_W-1:0]      action_seq,
	output logic                  refused
);

	`include "assert_macros.svh"

	state_t state_q, state_d;

	// config
	logic [NUM_SEQ_W-1:0] num_seq_q;
	logic [TIMEOUT_W-1:0] timeout_q;
	logic [TIMEOUT_W-1:0] timeout_eff;

	// latched item
	logic [CMD_W-1:0]  cmd_q;
	logic [SIDX_W-1:0] sidx_q;
	logic [KIDX_W-1:0] kidx_q;
	logic [SLEN_W-1:0] slen_q;
	logic [POS_W-1:0]  pos_q;

	// matcher state
	logic [KEY_CNT_W-1:0]     len_q [MAX_SEQUENCES];
	logic                     matching_q;
	logic [MAX_SEQUENCES-1:0] mask_q;
	logic [KEY_CNT_W-1:0]     press_q;
	logic                     pending_q;
	logic [SEQ_W-1:0]         pend_seq_q;
	logic                     fired_q;
	logic [SEQ_W-1:0]         fired_seq_q;
	logic [TIMEOUT_W-1:0]     timer_q;

	// walk
	logic [SEQ_W-1:0] idx_q;
	logic             rd_vld_s1;
	logic [SEQ_W-1:0] idx_s1;
	logic [POS_W-1:0] rd_data;
	walk_res_t        walk;

	// result path
	result_t res_q;
	result_t out_q;
	logic    out_valid_q;

	// control strobes
	held_op_t             held_op;
	logic                 held_hit;
	logic [KEY_CNT_W-1:0] held_count;
	logic                 ram_we;
	logic                 walk_clr;
	logic                 out_load;
	logic                 long_press;

	logic [MAX_SEQUENCES-1:0] act_mask;

	assign timeout_eff = (timeout_q == '0) ? TIMEOUT_W'(1) : timeout_q;
	assign long_press  = press_q >= KEY_CNT_W'(MAX_KEYS);

	// candidates on activation, saturating at the table size
	always_comb begin
		for (int i = 0; i < MAX_SEQUENCES; i++) begin
			act_mask[i] = int'(num_seq_q) > i;
		end
	end

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_seq_q <= '0;
			timeout_q <= TIMEOUT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_NUM_SEQUENCES: num_seq_q <= cfg_data[NUM_SEQ_W-1:0];
				REG_TIMEOUT_TICKS: timeout_q <= cfg_data[TIMEOUT_W-1:0];
				default: ;
			endcase
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				if (cmd_q == CMD_PRESS && matching_q) begin
					state_d = long_press ? ST_RESOLVE : ST_WALK;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_WALK: begin
				if (idx_q == SEQ_W'(MAX_SEQUENCES - 1)) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN:   state_d = ST_RESOLVE;
			ST_RESOLVE: state_d = ST_FIN;
			ST_FIN: begin
				if (!out_valid_q || out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// strobes
	always_comb begin
		in_ready       = 1'b0;
		held_op        = '0;
		ram_we         = 1'b0;
		walk_clr       = 1'b0;
		out_load       = 1'b0;
		case (state_q)
			ST_IDLE: in_ready = 1'b1;
			ST_DECODE: begin
				walk_clr       = 1'b1;
				ram_we         = cmd_q == CMD_LOAD;
				held_op.remove = cmd_q == CMD_RELEASE;
			end
			ST_RESOLVE: begin
				held_op.clear = walk.keep == '0;
				held_op.push  = walk.keep != '0;
			end
			ST_FIN: out_load = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// item capture
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_q  <= cmd;
			sidx_q <= seq_index;
			kidx_q <= key_index;
			slen_q <= seq_length;
			pos_q  <= position;
		end
	end

	// table walk address and read stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			rd_vld_s1 <= 1'b0;
			idx_s1    <= '0;
		end else begin
			idx_q     <= (state_q == ST_WALK) ? idx_q + SEQ_W'(1) : '0;
			rd_vld_s1 <= state_q == ST_WALK;
			idx_s1    <= idx_q;
		end
	end

	lksm_table_ram #(
		.AW(TBL_AW),
		.DW(POS_W)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr ({sidx_q, kidx_q}),
		.wdata (pos_q),
		.raddr ({idx_q, press_q[KEY_IDX_W-1:0]}),
		.rdata (rd_data)
	);

	lksm_walk u_walk (
		.clk     (clk),
		.arst_n  (arst_n),
		.clr     (walk_clr),
		.step    (rd_vld_s1),
		.idx     (idx_s1),
		.cand    (mask_q[idx_s1]),
		.len     (len_q[idx_s1]),
		.count   (press_q),
		.pos     (pos_q),
		.rd_data (rd_data),
		.res     (walk)
	);

	lksm_held u_held (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (held_op),
		.pos    (pos_q),
		.hit    (held_hit),
		.count  (held_count)
	);

	// sequence lengths, saturated on load
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_SEQUENCES; i++) begin
				len_q[i] <= '0;
			end
		end else if (state_q == ST_DECODE && cmd_q == CMD_LOAD) begin
			len_q[sidx_q] <= (slen_q > SLEN_W'(MAX_KEYS)) ? KEY_CNT_W'(MAX_KEYS)
			                                               : KEY_CNT_W'(slen_q);
		end
	end

	// command execution and press resolution
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			matching_q  <= 1'b0;
			mask_q      <= '0;
			press_q     <= '0;
			pending_q   <= 1'b0;
			pend_seq_q  <= '0;
			fired_q     <= 1'b0;
			fired_seq_q <= '0;
			timer_q     <= '0;
			res_q       <= '0;
		end else begin
			case (state_q)
				// result starts empty for every item
				ST_IDLE: res_q <= '0;
				ST_DECODE: begin
					case (cmd_q)
						CMD_ACTIVATE: begin
							if (held_count != '0) begin
								res_q.refused <= 1'b1;
							end else begin
								matching_q <= 1'b1;
								mask_q     <= act_mask;
								press_q    <= '0;
								pending_q  <= 1'b0;
								pend_seq_q <= '0;
								timer_q    <= '0;
							end
						end
						CMD_RELEASE: begin
							if (held_hit) begin
								res_q.consumed <= 1'b1;
								// last held key of a fired sequence
								if (held_count == KEY_CNT_W'(1) && fired_q) begin
									res_q.action <= ACT_RELEASE;
									res_q.seq    <= fired_seq_q;
									fired_q      <= 1'b0;
									fired_seq_q  <= '0;
								end
							end
						end
						CMD_TICK: begin
							if (timer_q != '0) begin
								timer_q <= timer_q - TIMEOUT_W'(1);
								if (timer_q == TIMEOUT_W'(1) && pending_q) begin
									res_q.action <= ACT_TAP;
									res_q.seq    <= pend_seq_q;
									matching_q   <= 1'b0;
									mask_q       <= '0;
									press_q      <= '0;
									pending_q    <= 1'b0;
									pend_seq_q   <= '0;
								end
							end
						end
						default: ;
					endcase
				end
				ST_RESOLVE: begin
					if (walk.keep == '0) begin
						// mismatch: cancel and pass the key on
						matching_q <= 1'b0;
						mask_q     <= '0;
						press_q    <= '0;
						pending_q  <= 1'b0;
						pend_seq_q <= '0;
						timer_q    <= '0;
					end else begin
						res_q.consumed <= 1'b1;
						if (walk.complete && !walk.longer) begin
							// fire now, held keys stay for the release
							res_q.action <= ACT_PRESS;
							res_q.seq    <= walk.done;
							fired_q      <= 1'b1;
							fired_seq_q  <= walk.done;
							matching_q   <= 1'b0;
							mask_q       <= '0;
							press_q      <= '0;
							pending_q    <= 1'b0;
							pend_seq_q   <= '0;
							timer_q      <= '0;
						end else begin
							mask_q  <= walk.keep;
							press_q <= press_q + KEY_CNT_W'(1);
							if (walk.complete) begin
								pending_q  <= 1'b1;
								pend_seq_q <= walk.done;
								timer_q    <= timeout_eff;
							end else begin
								pending_q  <= 1'b0;
								pend_seq_q <= '0;
								timer_q    <= '0;
							end
						end
					end
				end
				default: ;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= res_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign consumed   = out_q.consumed;
	assign action     = out_q.action;
	assign action_seq = out_q.seq;
	assign refused    = out_q.refused;

	`ASSERT_CLK(a_pending_in_match, pending_q |-> matching_q)
	`ASSERT_CLK(a_timer_has_pending, (timer_q != '0) |-> pending_q)
	`ASSERT_CLK(a_fired_keys_held, fired_q |-> (held_count != '0))
	`ASSERT_NEVER(a_fired_while_matching, fired_q && matching_q)

endmodule

FILE: verif/tb_top.sv
module tb_top;
	import lksm_pkg::*;

	localparam int ITEM_TARGET      = 1700;
	localparam int STALL_LIMIT      = 1000;
	localparam int SETTLE_CYCLES    = 40;
	localparam int MAX_MISMATCH_LOG = 10;
	localparam int RANDOM_PHASES    = 5;

	// Key positions used by the hand-built sequences
	localparam logic [POS_W-1:0] KEY_A    = 8'd1;
	localparam logic [POS_W-1:0] KEY_B    = 8'd2;
	localparam logic [POS_W-1:0] KEY_C    = 8'd3;
	localparam logic [POS_W-1:0] KEY_SOLO = 8'd6;
	localparam logic [POS_W-1:0] KEY_ALT  = 8'd7;
	localparam logic [POS_W-1:0] KEY_TOP  = 8'd255;
	localparam logic [POS_W-1:0] KEY_MISS = 8'd250;
	// Random sequences draw from a small alphabet so prefixes overlap
	localparam int ALPHABET_MAX = 5;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_ready;
	logic [CMD_W-1:0]      cmd;
	logic [SIDX_W-1:0]     seq_index;
	logic [KIDX_W-1:0]     key_index;
	logic [SLEN_W-1:0]     seq_length;
	logic [POS_W-1:0]      position;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic                  consumed;
	logic [ACT_W-1:0]      action;
	logic [SEQ_W-1:0]      action_seq;
	logic                  refused;

	leader_key_sequence_matcher u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.cmd        (cmd),
		.seq_index  (seq_index),
		.key_index  (key_index),
		.seq_length (seq_length),
		.position   (position),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.consumed   (consumed),
		.action     (action),
		.action_seq (action_seq),
		.refused    (refused)
	);

	// Shadow copy of the matcher state
	logic [POS_W-1:0]         tbl_pos [MAX_SEQUENCES*MAX_KEYS];
	logic [SLEN_W-1:0]        tbl_len [MAX_SEQUENCES];
	bit                       mt_active;
	logic [MAX_SEQUENCES-1:0] cand_mask;
	int unsigned              press_cnt;
	logic [POS_W-1:0]         held_pos [MAX_KEYS];
	int unsigned              held_cnt;
	bit                       pend_valid;
	logic [SEQ_W-1:0]         pend_seq;
	bit                       fire_valid;
	logic [SEQ_W-1:0]         fire_seq;
	bit                       fire_pressed;
	int unsigned              tick_left;
	logic [NUM_SEQ_W-1:0]     cfg_num_seq;
	logic [TIMEOUT_W-1:0]     cfg_timeout;

	result_t awaited_results [$];
	result_t head_r;
	int      err_count;
	int      items_sent;
	int      idle_cycles;
	bit      no_gaps;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic int unsigned live_sequences();
		return (cfg_num_seq > MAX_SEQUENCES) ? MAX_SEQUENCES : cfg_num_seq;
	endfunction

	task automatic log_error(input string msg);
		err_count++;
		if (err_count <= MAX_MISMATCH_LOG)
			$display("%s", msg);
	endtask

	task automatic close_match();
		mt_active  = 1'b0;
		cand_mask  = '0;
		press_cnt  = 0;
		pend_valid = 1'b0;
		pend_seq   = '0;
		tick_left  = 0;
	endtask

	// Advance the shadow state by one item and queue the result it gives
	task automatic predict_key_event(
		input logic [CMD_W-1:0]  c,
		input logic [SIDX_W-1:0] si,
		input logic [KIDX_W-1:0] ki,
		input logic [SLEN_W-1:0] sl,
		input logic [POS_W-1:0]  p
	);
		result_t                  r;
		logic [MAX_SEQUENCES-1:0] keep;
		bit                       complete;
		bit                       longer;
		bit                       hit;
		logic [SEQ_W-1:0]         done;
		int unsigned              cnt;
		int unsigned              len;
		r = '0;
		r.action = ACT_NONE;
		case (c)
			CMD_LOAD: begin
				tbl_pos[{si, ki}] = p;
				tbl_len[si] = (sl > MAX_KEYS) ? SLEN_W'(MAX_KEYS) : sl;
			end
			CMD_ACTIVATE: begin
				if (held_cnt != 0) begin
					r.refused = 1'b1;
				end else begin
					close_match();
					mt_active = 1'b1;
					for (int i = 0; i < live_sequences(); i++)
						cand_mask[i] = 1'b1;
				end
			end
			CMD_PRESS: begin
				if (mt_active) begin
					cnt = press_cnt;
					press_cnt = cnt + 1;
					keep = '0;
					complete = 1'b0;
					longer = 1'b0;
					done = '0;
					if (cnt < MAX_KEYS) begin
						for (int i = 0; i < MAX_SEQUENCES; i++) begin
							len = tbl_len[i];
							if (cand_mask[i] && cnt < len && tbl_pos[i*MAX_KEYS+cnt] == p) begin
								keep[i] = 1'b1;
								if (len == cnt + 1) begin
									complete = 1'b1;
									done = SEQ_W'(i);
								end else begin
									longer = 1'b1;
								end
							end
						end
					end
					cand_mask = keep;
					if (keep == '0) begin
						// mismatch: drop matching and forget held keys
						close_match();
						held_cnt = 0;
					end else begin
						r.consumed = 1'b1;
						if (held_cnt < MAX_KEYS) begin
							held_pos[held_cnt] = p;
							held_cnt++;
						end
						if (complete && !longer) begin
							close_match();
							fire_valid = 1'b1;
							fire_seq = done;
							fire_pressed = 1'b1;
							r.action = ACT_PRESS;
							r.seq = done;
						end else if (complete) begin
							pend_valid = 1'b1;
							pend_seq = done;
							tick_left = (cfg_timeout == 0) ? 1 : cfg_timeout;
						end else begin
							pend_valid = 1'b0;
							pend_seq = '0;
							tick_left = 0;
						end
					end
				end
			end
			CMD_RELEASE: begin
				hit = 1'b0;
				for (int i = 0; i < held_cnt && !hit; i++) begin
					if (held_pos[i] == p) begin
						hit = 1'b1;
						for (int j = i; j + 1 < held_cnt; j++)
							held_pos[j] = held_pos[j+1];
						held_cnt--;
						r.consumed = 1'b1;
						if (held_cnt == 0 && fire_valid) begin
							if (fire_pressed) begin
								r.action = ACT_RELEASE;
								r.seq = fire_seq;
							end
							fire_valid = 1'b0;
							fire_seq = '0;
							fire_pressed = 1'b0;
						end
					end
				end
			end
			CMD_TICK: begin
				if (tick_left > 0) begin
					tick_left--;
					if (tick_left == 0 && pend_valid) begin
						r.action = ACT_TAP;
						r.seq = pend_seq;
						close_match();
					end
				end
			end
			default: ;
		endcase
		awaited_results.push_back(r);
	endtask

	// Offer one item after an optional gap; valid stays up until the next call
	task automatic send_item(
		input logic [CMD_W-1:0]  c,
		input logic [SIDX_W-1:0] si,
		input logic [KIDX_W-1:0] ki,
		input logic [SLEN_W-1:0] sl,
		input logic [POS_W-1:0]  p
	);
		int gap;
		gap = 0;
		if (!no_gaps && $urandom_range(0, 99) < 25)
			gap = $urandom_range(1, 6);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		cmd        <= c;
		seq_index  <= si;
		key_index  <= ki;
		seq_length <= sl;
		position   <= p;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_key_event(c, si, ki, sl, p);
		if (c <= CMD_TICK)
			items_sent++;
	endtask

	// Unused fields get random values
	task automatic send_cmd(input logic [CMD_W-1:0] c, input logic [POS_W-1:0] p);
		send_item(c, SIDX_W'($urandom), KIDX_W'($urandom), SLEN_W'($urandom), p);
	endtask

	task automatic send_unknown();
		logic [CMD_W-1:0] c;
		c = CMD_TICK;
		c = c + CMD_W'($urandom_range(1, 3));
		send_cmd(c, POS_W'($urandom));
	endtask

	// Stop sending, wait for every result, then let the block settle
	task automatic drain_block();
		in_valid <= 1'b0;
		while (awaited_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		drain_block();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_NUM_SEQUENCES)
			cfg_num_seq = data[NUM_SEQ_W-1:0];
		else
			cfg_timeout = data[TIMEOUT_W-1:0];
	endtask

	// Let go of every held key in random order, with a stray release now and then
	task automatic release_held();
		int unsigned idx;
		while (held_cnt > 0) begin
			if ($urandom_range(0, 9) == 0) begin
				send_cmd(CMD_RELEASE, POS_W'($urandom));
			end else begin
				idx = $urandom_range(0, held_cnt - 1);
				send_cmd(CMD_RELEASE, held_pos[idx]);
			end
		end
	endtask

	// Activate and walk one live sequence, with stray keys, ticks and early stops
	task automatic run_episode();
		int unsigned n;
		int unsigned s;
		int unsigned k;
		int unsigned waited;
		int          r;
		if (held_cnt > 0) begin
			if ($urandom_range(0, 3) == 0)
				send_cmd(CMD_ACTIVATE, POS_W'($urandom));
			release_held();
		end
		n = live_sequences();
		send_cmd(CMD_ACTIVATE, POS_W'($urandom));
		s = (n == 0) ? 0 : $urandom_range(0, n - 1);
		k = 0;
		while (mt_active && k < MAX_KEYS) begin
			r = $urandom_range(0, 99);
			if (r < 5) begin
				send_cmd(CMD_PRESS, POS_W'($urandom));
			end else if (r < 10 && k > 0) begin
				break;
			end else if (r < 18) begin
				send_cmd(CMD_TICK, POS_W'($urandom));
			end else begin
				if (k < tbl_len[s])
					send_cmd(CMD_PRESS, tbl_pos[s*MAX_KEYS+k]);
				else
					send_cmd(CMD_PRESS, POS_W'($urandom_range(0, ALPHABET_MAX)));
				k++;
			end
		end
		waited = 0;
		while (pend_valid && waited < 6) begin
			send_cmd(CMD_TICK, POS_W'($urandom));
			waited++;
		end
		release_held();
	endtask

	task automatic random_step();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			run_episode();
		else if (r < 78)
			send_item(CMD_LOAD, SIDX_W'($urandom), KIDX_W'($urandom), SLEN_W'($urandom),
				$urandom_range(0, 1) ? POS_W'($urandom) : POS_W'($urandom_range(0, ALPHABET_MAX)));
		else if (r < 84)
			send_cmd(CMD_PRESS, POS_W'($urandom));
		else if (r < 90)
			send_cmd(CMD_RELEASE, (held_cnt > 0 && $urandom_range(0, 1)) ?
				held_pos[$urandom_range(0, held_cnt - 1)] : POS_W'($urandom));
		else if (r < 95)
			send_cmd(CMD_TICK, POS_W'($urandom));
		else if (r < 98)
			send_cmd(CMD_ACTIVATE, POS_W'($urandom));
		else
			send_unknown();
	endtask

	// Out of reset: no live sequences, nothing held, stray commands ignored
	task automatic test_reset_state();
		send_cmd(CMD_TICK, POS_W'($urandom));
		send_cmd(CMD_ACTIVATE, POS_W'($urandom));
		send_cmd(CMD_PRESS, '0);
		send_cmd(CMD_RELEASE, KEY_TOP);
		repeat (3) send_unknown();
	endtask

	// Write every table slot; a few hand-built sequences, the rest may share prefixes
	task automatic test_table_fill();
		logic [POS_W-1:0]  slot [MAX_KEYS];
		logic [SLEN_W-1:0] slen_field;
		int unsigned       len;
		int unsigned       share;
		int unsigned       src;
		for (int s = 0; s < MAX_SEQUENCES; s++) begin
			// slots past the length keep full-range values that must never match
			for (int k = 0; k < MAX_KEYS; k++)
				slot[k] = POS_W'($urandom);
			case (s)
				0, 2: begin
					len = 2;
					slot[0] = KEY_A;
					slot[1] = KEY_B;
				end
				1: begin
					len = 3;
					slot[0] = KEY_A;
					slot[1] = KEY_B;
					slot[2] = KEY_C;
				end
				3: begin
					len = MAX_KEYS;
					for (int k = 0; k < MAX_KEYS; k++)
						slot[k] = (k % 2) ? KEY_ALT : KEY_TOP;
				end
				4: len = 0;
				5: begin
					len = 1;
					slot[0] = KEY_SOLO;
				end
				default: begin
					len = $urandom_range(1, MAX_KEYS);
					src = (s > 6) ? $urandom_range(6, s - 1) : 6;
					share = (s > 6) ? $urandom_range(0, len) : 0;
					if (s > 6 && share > tbl_len[src])
						share = tbl_len[src];
					for (int k = 0; k < len; k++)
						slot[k] = (k < share) ? tbl_pos[src*MAX_KEYS+k] :
							POS_W'($urandom_range(0, ALPHABET_MAX));
				end
			endcase
			slen_field = SLEN_W'(len);
			// lengths above the key count saturate
			if (s == 3 || (len == MAX_KEYS && $urandom_range(0, 1)))
				slen_field = SLEN_W'($urandom_range(MAX_KEYS + 1, 15));
			for (int k = 0; k < MAX_KEYS; k++)
				send_item(CMD_LOAD, SIDX_W'(s), KIDX_W'(k),
					(k == MAX_KEYS - 1) ? slen_field : SLEN_W'($urandom), slot[k]);
		end
	endtask

	// Ambiguous prefix waits out the reset timeout before the tap
	task automatic test_default_timeout();
		int guard;
		cfg_write(REG_NUM_SEQUENCES, CFG_DATA_W'(MAX_SEQUENCES));
		send_cmd(CMD_ACTIVATE, POS_W'($urandom));
		send_cmd(CMD_PRESS, KEY_A);
		send_cmd(CMD_PRESS, KEY_B);
		guard = 0;
		while (pend_valid && guard < 600) begin
			send_cmd(CMD_TICK, POS_W'($urandom));
			guard++;
		end
		release_held();
	endtask

	task automatic test_directed();
		cfg_write(REG_TIMEOUT_TICKS, CFG_DATA_W'(3));
		// sole candidate fires at once, its last release follows
		send_cmd(CMD_ACTIVATE, POS_W'($urandom));
		send_cmd(CMD_PRESS, KEY_SOLO);
		send_cmd(CMD_RELEASE, KEY_SOLO);
		// longest sequence
		send_cmd(CMD_ACTIVATE, POS_W'($urandom));
		for (int k = 0; k < MAX_KEYS; k++)
			send_cmd(CMD_PRESS, (k % 2) ? KEY_ALT : KEY_TOP);
		release_held();
		// wrong key cancels; the earlier key is no longer held
		send_cmd(CMD_ACTIVATE, POS_W'($urandom));
		send_cmd(CMD_PRESS, KEY_A);
		send_cmd(CMD_PRESS, KEY_MISS);
		send_cmd(CMD_RELEASE, KEY_A);
		// press while idle
		send_cmd(CMD_PRESS, KEY_C);
		// activation refused with a key held, then cancel
		send_cmd(CMD_ACTIVATE, POS_W'($urandom));
		send_cmd(CMD_PRESS, KEY_A);
		send_cmd(CMD_ACTIVATE, POS_W'($urandom));
		send_cmd(CMD_PRESS, KEY_TOP);
		// restart while matching, then tap after the timeout
		send_cmd(CMD_ACTIVATE, POS_W'($urandom));
		send_cmd(CMD_ACTIVATE, POS_W'($urandom));
		send_cmd(CMD_PRESS, KEY_A);
		send_cmd(CMD_PRESS, KEY_B);
		repeat (3) send_cmd(CMD_TICK, POS_W'($urandom));
		release_held();
		// timer stopped
		send_cmd(CMD_TICK, POS_W'($urandom));
		// zero timeout behaves as one tick
		cfg_write(REG_TIMEOUT_TICKS, '0);
		send_cmd(CMD_ACTIVATE, POS_W'($urandom));
		send_cmd(CMD_PRESS, KEY_A);
		send_cmd(CMD_PRESS, KEY_B);
		send_cmd(CMD_TICK, POS_W'($urandom));
		release_held();
		// one live sequence: the short prefix has no longer rival
		cfg_write(REG_NUM_SEQUENCES, CFG_DATA_W'(1));
		send_cmd(CMD_ACTIVATE, POS_W'($urandom));
		send_cmd(CMD_PRESS, KEY_A);
		send_cmd(CMD_PRESS, KEY_B);
		release_held();
	endtask

	task automatic test_random();
		logic [CFG_DATA_W-1:0] nval;
		logic [CFG_DATA_W-1:0] tval;
		int                    phase_end;
		int                    half;
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			case (ph)
				0: begin
					nval = CFG_DATA_W'(MAX_SEQUENCES);
					tval = CFG_DATA_W'(2);
				end
				1: begin
					// above the table size, with junk in the upper bits
					nval = {10'($urandom), 6'd63};
					tval = CFG_DATA_W'(1);
				end
				2: begin
					nval = CFG_DATA_W'(12);
					tval = CFG_DATA_W'(4);
				end
				3: begin
					nval = CFG_DATA_W'(MAX_SEQUENCES);
					tval = '1;
				end
				default: begin
					nval = CFG_DATA_W'($urandom_range(0, 40));
					tval = CFG_DATA_W'($urandom_range(1, 5));
				end
			endcase
			cfg_write(REG_NUM_SEQUENCES, nval);
			cfg_write(REG_TIMEOUT_TICKS, tval);
			no_gaps = (ph == 2);
			phase_end = items_sent + (ITEM_TARGET - items_sent) / (RANDOM_PHASES - ph);
			half = (items_sent + phase_end) / 2;
			while (items_sent < phase_end) begin
				// hold off once mid-phase until every result is back
				if (ph == 0 && half > 0 && items_sent >= half) begin
					drain_block();
					half = 0;
				end
				random_step();
			end
		end
		no_gaps = 1'b0;
	endtask

	// Receiver stalls about a quarter of the cycles
	always @(posedge clk)
		out_ready <= no_gaps ? 1'b1 : ($urandom_range(0, 99) >= 25);

	// Result checker
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (awaited_results.size() == 0) begin
				log_error($sformatf("unexpected result: consumed=%0d action=%0d seq=%0d refused=%0d",
					consumed, action, action_seq, refused));
			end else begin
				head_r = awaited_results.pop_front();
				if (consumed !== head_r.consumed || action !== head_r.action ||
						action_seq !== head_r.seq || refused !== head_r.refused)
					log_error($sformatf({"mismatch: expected consumed=%0d action=%0d seq=%0d refused=%0d",
						", got consumed=%0d action=%0d seq=%0d refused=%0d"},
						head_r.consumed, head_r.action, head_r.seq, head_r.refused,
						consumed, action, action_seq, refused));
			end
		end
	end

	// Watchdog on cycles with no handshake on either channel
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("[leader_key_sequence_matcher] ERROR");
			$finish;
		end
	end

	initial begin
		arst_n     = 1'b0;
		cfg_we     = 1'b0;
		cfg_index  = REG_NUM_SEQUENCES;
		cfg_data   = '0;
		in_valid   = 1'b0;
		cmd        = CMD_LOAD;
		seq_index  = '0;
		key_index  = '0;
		seq_length = '0;
		position   = '0;
		err_count   = 0;
		items_sent  = 0;
		idle_cycles = 0;
		no_gaps     = 1'b0;
		// shadow state after reset
		for (int i = 0; i < MAX_SEQUENCES; i++)
			tbl_len[i] = '0;
		close_match();
		held_cnt     = 0;
		fire_valid   = 1'b0;
		fire_seq     = '0;
		fire_pressed = 1'b0;
		cfg_num_seq  = '0;
		cfg_timeout  = TIMEOUT_RESET;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_table_fill();
		test_default_timeout();
		test_directed();
		test_random();

		drain_block();
		if (awaited_results.size() != 0)
			log_error($sformatf("%0d results never arrived", awaited_results.size()));
		if (err_count == 0)
			$display("[leader_key_sequence_matcher] OK");
		else
			$display("[leader_key_sequence_matcher] ERROR");
		$finish;
	end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/lksm_pkg.sv
rtl/core/lksm_table_ram.sv
rtl/core/lksm_held.sv
rtl/core/lksm_walk.sv
rtl/core/leader_key_sequence_matcher.sv
verif/tb_top.sv
